[hw/rtl/wfg_pkg.sv]
// Shared types, constants and coefficient tables of the window coefficient generator.
package wfg_pkg;

    localparam int DEFAULT_MAX_LENGTH = 4096;
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int TYPE_W = 4;
    localparam int COEF_W = 21;
    localparam int SUM_W  = 36;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd1024;

    localparam logic [TYPE_W-1:0] WIN_NONE     = 4'd0;
    localparam logic [TYPE_W-1:0] WIN_CONSTANT = 4'd1;
    localparam logic [TYPE_W-1:0] WIN_RAISED   = 4'd2;
    localparam logic [TYPE_W-1:0] WIN_HAMMING  = 4'd3;
    localparam logic [TYPE_W-1:0] WIN_HANN     = 4'd4;
    localparam logic [TYPE_W-1:0] WIN_BLACKMAN = 4'd5;
    localparam logic [TYPE_W-1:0] WIN_BHARRIS  = 4'd6;
    localparam logic [TYPE_W-1:0] WIN_GAUSSIAN = 4'd7;
    localparam logic [TYPE_W-1:0] WIN_FLAT_TOP = 4'd8;

    localparam int CORDIC_STEPS = 17;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    // exponent argument at which the Gaussian underflows to zero (12.0 in Q16)
    localparam logic [22:0] GAUSS_LIMIT = 23'd786432;
    localparam logic [31:0] GAUSS_SCALE = 32'd50;

    typedef struct packed {
        logic        start;
        logic [25:0] rem_init;
        logic [48:0] num;
        logic [25:0] divisor;
        logic [5:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [22:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [19:0] phase;
    } t_cor_req;

    typedef struct packed {
        logic               done;
        logic signed [17:0] cosine;
    } t_cor_rsp;

    // cosine term weights in Q16, term k multiplies cos(2 pi k i / D)
    function automatic logic signed [17:0] weight(input logic [3:0] t, input logic [2:0] k);
        logic signed [17:0] w;
        w = '0;
        unique case (t)
            WIN_NONE:     if (k == 3'd0) w = 18'sd65536;
            WIN_CONSTANT: if (k == 3'd0) w = 18'sd46334;
            WIN_RAISED, WIN_HANN: begin
                if (k == 3'd0) w = 18'sd32768;
                if (k == 3'd1) w = -18'sd32768;
            end
            WIN_HAMMING: begin
                if (k == 3'd0) w = 18'sd35389;
                if (k == 3'd1) w = -18'sd30147;
            end
            WIN_BLACKMAN: begin
                if (k == 3'd0) w = 18'sd27525;
                if (k == 3'd1) w = -18'sd32768;
                if (k == 3'd2) w = 18'sd5243;
            end
            WIN_BHARRIS: begin
                if (k == 3'd0) w = 18'sd27737;
                if (k == 3'd1) w = -18'sd32607;
                if (k == 3'd2) w = 18'sd5192;
            end
            WIN_FLAT_TOP: begin
                if (k == 3'd0) w = 18'sd65536;
                if (k == 3'd1) w = -18'sd126484;
                if (k == 3'd2) w = 18'sd84541;
                if (k == 3'd3) w = -18'sd25428;
                if (k == 3'd4) w = 18'sd2097;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // rotation angles in Q20 turns
    function automatic logic [17:0] atan_q20(input logic [4:0] idx);
        logic [17:0] a;
        unique case (idx)
            5'd0:  a = 18'd131072;
            5'd1:  a = 18'd77376;
            5'd2:  a = 18'd40884;
            5'd3:  a = 18'd20753;
            5'd4:  a = 18'd10417;
            5'd5:  a = 18'd5213;
            5'd6:  a = 18'd2607;
            5'd7:  a = 18'd1304;
            5'd8:  a = 18'd652;
            5'd9:  a = 18'd326;
            5'd10: a = 18'd163;
            5'd11: a = 18'd81;
            5'd12: a = 18'd41;
            5'd13: a = 18'd20;
            5'd14: a = 18'd10;
            5'd15: a = 18'd5;
            5'd16: a = 18'd3;
            default: a = '0;
        endcase
        return a;
    endfunction

    // exp(-2^(j-16)) in Q30
    function automatic logic [29:0] exp_q30(input logic [4:0] j);
        logic [29:0] e;
        unique case (j)
            5'd0:  e = 30'd1073725440;
            5'd1:  e = 30'd1073709056;
            5'd2:  e = 30'd1073676290;
            5'd3:  e = 30'd1073610760;
            5'd4:  e = 30'd1073479712;
            5'd5:  e = 30'd1073217664;
            5'd6:  e = 30'd1072693761;
            5'd7:  e = 30'd1071646719;
            5'd8:  e = 30'd1069553824;
            5'd9:  e = 30'd1065385899;
            5'd10: e = 30'd1057095001;
            5'd11: e = 30'd1040706261;
            5'd12: e = 30'd1008687095;
            5'd13: e = 30'd947573834;
            5'd14: e = 30'd836230973;
            5'd15: e = 30'd651257332;
            5'd16: e = 30'd395007542;
            5'd17: e = 30'd145315154;
            5'd18: e = 30'd19666268;
            5'd19: e = 30'd360200;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/wfg_mul.sv]
// Shared signed 32 x 32 multiplier with registered product.
module wfg_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/wfg_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module wfg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfg_pkg::t_div_req i_req,
    output wfg_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [25:0] r_rem;
    logic [48:0] r_num;
    logic [25:0] r_div;
    logic [22:0] r_quot;
    logic [5:0]  r_cnt;
    logic [26:0] trial;
    logic [26:0] diff;
    logic        fits;

    assign trial = {r_rem, r_num[48]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.rem_init;
                r_num  <= i_req.num;
                r_div  <= i_req.divisor;
                r_cnt  <= i_req.steps;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[25:0] : trial[25:0];
                r_num  <= {r_num[47:0], 1'b0};
                r_quot <= {r_quot[21:0], fits};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[hw/rtl/wfg_cordic.sv]
// Iterative CORDIC cosine of a 20-bit phase, one rotation per cycle.
module wfg_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfg_pkg::t_cor_req i_req,
    output wfg_pkg::t_cor_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [4:0]         r_i;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [20:0] r_z;
    logic signed [20:0] z0;
    logic signed [20:0] zf;
    logic               negf;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [20:0] ang;
    logic signed [32:0] xr;
    logic signed [17:0] cl;

    // fold into a quarter turn either side of zero; a half-turn shift negates
    always_comb begin
        z0   = {i_req.phase[19], i_req.phase};
        zf   = z0;
        negf = 1'b0;
        if (z0 > 21'sd262144) begin
            zf   = z0 - 21'sd524288;
            negf = 1'b1;
        end else if (z0 < -21'sd262144) begin
            zf   = z0 + 21'sd524288;
            negf = 1'b1;
        end
    end

    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign ang = {3'b000, wfg_pkg::atan_q20(r_i)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_x    <= wfg_pkg::CORDIC_X0;
                r_y    <= '0;
                r_z    <= zf;
                r_neg  <= negf;
                r_i    <= '0;
            end else if (r_busy) begin
                if (!r_z[20]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(wfg_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        xr = (r_x + 33'sd8192) >>> 14;
        if (xr > 33'sd65536) begin
            cl = 18'sd65536;
        end else if (xr < -33'sd65536) begin
            cl = -18'sd65536;
        end else begin
            cl = xr[17:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.cosine = r_neg ? -cl : cl;

endmodule

[hw/rtl/fft_window_coefficient_generator.sv]
// Top level: sequencer that builds window coefficients and their running sum.
//
// One sample index is taken at a time; the input stalls until its result is
// loaded into the output register. Unused codes and an index beyond the
// window length go straight to the output, and none and constant need no
// cosine term. Each cosine term takes one modulo step, a divider pass for 20
// quotient bits, 17 CORDIC rotations and one multiply-add; Hann, Hamming and
// raised cosine have one term, Blackman and Blackman-Harris two and flat top
// four. Gaussian runs a divider pass for 49 quotient bits and, unless the
// exponent argument underflows, the serial exponential product with one
// multiply per set bit of the argument. A stalled output register holds the
// sequencer until the result can be loaded. The divider and the 32 x 32
// multiplier are shared by the cosine terms and the Gaussian steps, and the
// CORDIC unit by all cosine terms. An index at or beyond the window length
// returns a flag, a zero coefficient and the unchanged sum. The window
// length is clamped to 2 .. MAX_LENGTH.
module fft_window_coefficient_generator #(
    parameter int MAX_LENGTH = wfg_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wfg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wfg_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wfg_pkg::IDX_W-1:0]           i_sample_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [wfg_pkg::COEF_W-1:0]   o_coefficient,
    output logic signed [wfg_pkg::SUM_W-1:0]    o_running_sum,
    output logic                                o_index_out_of_range
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_COR  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_RND  = 4'd6;
    localparam logic [3:0] S_G0   = 4'd7;
    localparam logic [3:0] S_G1   = 4'd8;
    localparam logic [3:0] S_G2   = 4'd9;
    localparam logic [3:0] S_G3   = 4'd10;
    localparam logic [3:0] S_GDIV = 4'd11;
    localparam logic [3:0] S_GEXP = 4'd12;
    localparam logic [3:0] S_GMUL = 4'd13;
    localparam logic [3:0] S_GOUT = 4'd14;
    localparam logic [3:0] S_FIN  = 4'd15;

    localparam logic [16:0] MAX_L = 17'(MAX_LENGTH);

    logic [3:0]         r_state;
    logic [3:0]         r_type;
    logic [12:0]        r_len;
    logic signed [35:0] r_sum;
    logic [11:0]        r_idx;
    logic [12:0]        r_d;
    logic               r_oor;
    logic [12:0]        r_m;
    logic [2:0]         r_k;
    logic signed [39:0] r_acc;
    logic signed [20:0] r_coef;
    logic [25:0]        r_sq;
    logic [25:0]        r_dd;
    logic [19:0]        r_a;
    logic [30:0]        r_r;
    logic [4:0]         r_j;
    logic               r_out_valid;
    logic signed [20:0] r_out_coef;
    logic signed [35:0] r_out_sum;
    logic               r_out_oor;

    logic [12:0]        len_eff;
    logic               accept;
    logic               load;
    logic signed [17:0] w_cur;
    logic signed [17:0] w0;
    logic [13:0]        m_sum;
    logic [12:0]        m_next;
    logic [12:0]        two_i;
    logic [12:0]        s_abs;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] g_rnd;
    logic signed [39:0] acc_rnd;
    logic signed [20:0] coef_sat;
    logic [30:0]        r_plus;
    logic signed [36:0] sum_add;
    logic signed [35:0] sum_new;

    wfg_pkg::t_div_req div_req;
    wfg_pkg::t_div_rsp div_rsp;
    wfg_pkg::t_cor_req cor_req;
    wfg_pkg::t_cor_rsp cor_rsp;

    wfg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    wfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    wfg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign load        = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_len < 13'd2) begin
            len_eff = 13'd2;
        end else if ({4'b0000, r_len} > MAX_L) begin
            len_eff = MAX_L[12:0];
        end else begin
            len_eff = r_len;
        end
    end

    assign w_cur = wfg_pkg::weight(r_type, r_k);
    assign w0    = wfg_pkg::weight(r_type, 3'd0);

    // phase index advances by i per term: (m + i) stays below 2D
    assign m_sum  = {1'b0, r_m} + {2'b00, r_idx};
    assign m_next = (m_sum >= {1'b0, r_d}) ? 13'(m_sum - {1'b0, r_d}) : m_sum[12:0];

    assign two_i = {r_idx, 1'b0};
    assign s_abs = (two_i >= r_d) ? two_i - r_d : r_d - two_i;

    always_comb begin
        div_req.start = ((r_state == S_MOD) && (w_cur != '0)) || (r_state == S_G3);
        if (r_state == S_G3) begin
            div_req.rem_init = '0;
            div_req.num      = {prod[32:0], 16'b0} + {24'b0, r_dd[25:1]};
            div_req.divisor  = r_dd;
            div_req.steps    = 6'd49;
        end else begin
            div_req.rem_init = {13'b0, m_next};
            div_req.num      = {8'b0, r_d[12:1], 29'b0};
            div_req.divisor  = {13'b0, r_d};
            div_req.steps    = 6'd20;
        end
    end

    assign cor_req.start = (r_state == S_DIV) && div_rsp.done;
    assign cor_req.phase = div_rsp.quot[19:0];

    always_comb begin
        unique case (r_state)
            S_COR: begin
                mul_a = {{14{w_cur[17]}}, w_cur};
                mul_b = {{14{cor_rsp.cosine[17]}}, cor_rsp.cosine};
            end
            S_G0: begin
                mul_a = {19'b0, s_abs};
                mul_b = {19'b0, s_abs};
            end
            S_G1: begin
                mul_a = {19'b0, r_d};
                mul_b = {19'b0, r_d};
            end
            S_G2: begin
                mul_a = {6'b0, r_sq};
                mul_b = wfg_pkg::GAUSS_SCALE;
            end
            S_GEXP: begin
                mul_a = {1'b0, r_r};
                mul_b = {2'b00, wfg_pkg::exp_q30(r_j)};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign g_rnd   = prod + 64'sd536870912;
    assign acc_rnd = (r_acc + 40'sd32768) >>> 16;
    assign r_plus  = r_r + 31'd8192;

    always_comb begin
        if (acc_rnd > 40'sd1048575) begin
            coef_sat = 21'sd1048575;
        end else if (acc_rnd < -40'sd1048576) begin
            coef_sat = -21'sd1048576;
        end else begin
            coef_sat = acc_rnd[20:0];
        end
    end

    assign sum_add = {r_sum[35], r_sum} + {{16{r_coef[20]}}, r_coef};

    always_comb begin
        if (r_idx == '0) begin
            sum_new = {{15{r_coef[20]}}, r_coef};
        end else if (sum_add[36] != sum_add[35]) begin
            // saturate on overflow
            sum_new = sum_add[36] ? {1'b1, 35'b0} : {1'b0, {35{1'b1}}};
        end else begin
            sum_new = sum_add[35:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type      <= wfg_pkg::WIN_NONE;
            r_len       <= wfg_pkg::LENGTH_RESET;
            r_sum       <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == wfg_pkg::REG_WINDOW_TYPE) begin
                    r_type <= i_cfg_data[3:0];
                end else if (i_cfg_index == wfg_pkg::REG_WINDOW_LENGTH) begin
                    r_len <= i_cfg_data;
                end
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= i_sample_index;
                        r_d     <= len_eff - 13'd1;
                        r_oor   <= {1'b0, i_sample_index} >= len_eff;
                        r_coef  <= '0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_oor || (r_type > wfg_pkg::WIN_FLAT_TOP)) begin
                        r_state <= S_FIN;
                    end else if (r_type == wfg_pkg::WIN_GAUSSIAN) begin
                        r_state <= S_G0;
                    end else begin
                        r_acc   <= {{6{w0[17]}}, w0, 16'b0};
                        r_k     <= 3'd1;
                        r_m     <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_m <= m_next;
                    if (w_cur != '0) begin
                        r_state <= S_DIV;
                    end else if (r_k == 3'd4) begin
                        r_state <= S_RND;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_COR;
                    end
                end
                S_COR: begin
                    if (cor_rsp.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc <= r_acc + prod[39:0];
                    if (r_k == 3'd4) begin
                        r_state <= S_RND;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MOD;
                    end
                end
                S_RND: begin
                    r_coef  <= coef_sat;
                    r_state <= S_FIN;
                end
                S_G0: begin
                    r_state <= S_G1;
                end
                S_G1: begin
                    r_sq    <= prod[25:0];
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_dd    <= prod[25:0];
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_state <= S_GDIV;
                end
                S_GDIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot >= wfg_pkg::GAUSS_LIMIT) begin
                            r_state <= S_FIN;
                        end else begin
                            r_a     <= div_rsp.quot[19:0];
                            r_r     <= 31'd1073741824;
                            r_j     <= 5'd19;
                            r_state <= S_GEXP;
                        end
                    end
                end
                S_GEXP: begin
                    if (r_a[r_j]) begin
                        r_state <= S_GMUL;
                    end else if (r_j == '0) begin
                        r_state <= S_GOUT;
                    end else begin
                        r_j <= r_j - 5'd1;
                    end
                end
                S_GMUL: begin
                    r_r <= g_rnd[60:30];
                    if (r_j == '0) begin
                        r_state <= S_GOUT;
                    end else begin
                        r_j     <= r_j - 5'd1;
                        r_state <= S_GEXP;
                    end
                end
                S_GOUT: begin
                    r_coef  <= {4'b0000, r_plus[30:14]};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (load) begin
                        r_out_coef <= r_coef;
                        r_out_oor  <= r_oor;
                        if (r_oor) begin
                            r_out_sum <= r_sum;
                        end else begin
                            r_out_sum <= sum_new;
                            r_sum     <= sum_new;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_coefficient        = r_out_coef;
    assign o_running_sum        = r_out_sum;
    assign o_index_out_of_range = r_out_oor;

endmodule
